/* src/vgl_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vgl_pkg
// Shared widths, register map and control structs of the VAR(1) Gaussian
// log-likelihood accumulator.
// ----------------------------------------------------------------------------
package vgl_pkg;

    localparam int LANES     = 4;
    localparam int ELEM_W    = 16;
    localparam int REG_W     = 64;
    localparam int CFG_IDX_W = 3;
    localparam int JAC_W     = 40;
    localparam int SUM_W     = 48;
    localparam int SUM_FRAC  = 24;

    // A 16 x 16 product, four of them summed, and that sum times an element.
    localparam int PROD_W    = 2 * ELEM_W;
    localparam int INNER_W   = PROD_W + 2;
    localparam int TERM_W    = ELEM_W + INNER_W;

    // Stream packing.
    localparam int SERIES_LSB  = LANES * ELEM_W;
    localparam int JAC_LSB     = 2 * LANES * ELEM_W;
    localparam int IN_TDATA_W  = JAC_LSB + JAC_W;
    localparam int OUT_TDATA_W = SUM_W;

    // Register map: coefficient rows first, then precision rows.
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_BASE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PREC_BASE = 3'd4;

    typedef logic signed [ELEM_W-1:0] t_elem;

    typedef struct packed {
        logic err_mul;
        logic err_sum;
        logic prec_mul;
        logic inner_sum;
        logic form_mul;
    } t_lane_ctl;

    typedef struct packed {
        logic form_sum;
        logic commit;
    } t_merge_ctl;

endpackage
`default_nettype wire

/* src/vgl_lane.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vgl_lane
// One element lane: forms its error element from the coefficient row and the
// previous column, then its share e_i * (P_i . e) of the quadratic form.
// ----------------------------------------------------------------------------
module vgl_lane #(
    parameter int  FRAC_BITS = 12,
    parameter bit  LANE_ON   = 1'b1
) (
    input  wire                          i_clk,
    input  wire vgl_pkg::t_lane_ctl      i_ctl,
    input  wire [vgl_pkg::REG_W-1:0]     i_coef_row,
    input  wire [vgl_pkg::REG_W-1:0]     i_prec_row,
    input  wire vgl_pkg::t_elem          i_prev [vgl_pkg::LANES],
    input  wire vgl_pkg::t_elem          i_resid,
    input  wire                          i_first,
    input  wire vgl_pkg::t_elem          i_err_all [vgl_pkg::LANES],
    output vgl_pkg::t_elem               o_err,
    output logic                         o_hit,
    output logic signed [vgl_pkg::TERM_W-1:0] o_term
);

    localparam int ERR_ACC_W =
        ((vgl_pkg::ELEM_W + FRAC_BITS) > (vgl_pkg::PROD_W + 2) ?
         (vgl_pkg::ELEM_W + FRAC_BITS) : (vgl_pkg::PROD_W + 2)) + 2;
    localparam logic signed [ERR_ACC_W-1:0] ERR_HALF = ERR_ACC_W'(1) << (FRAC_BITS - 1);
    localparam logic signed [ERR_ACC_W-1:0] ERR_MAX  =
        ERR_ACC_W'((1 << (vgl_pkg::ELEM_W - 1)) - 1);
    localparam logic signed [ERR_ACC_W-1:0] ERR_MIN  = ~ERR_MAX;

    logic signed [vgl_pkg::PROD_W-1:0]  r_cprod [vgl_pkg::LANES];
    logic signed [vgl_pkg::PROD_W-1:0]  r_pprod [vgl_pkg::LANES];
    logic signed [vgl_pkg::INNER_W-1:0] r_inner;
    vgl_pkg::t_elem                     r_err;
    logic                               r_hit;
    logic signed [vgl_pkg::TERM_W-1:0]  r_term;

    logic signed [ERR_ACC_W-1:0]        w_acc;
    logic signed [ERR_ACC_W-1:0]        w_rnd;
    logic signed [ERR_ACC_W-1:0]        w_shift;
    logic signed [vgl_pkg::INNER_W-1:0] w_inner;
    vgl_pkg::t_elem                     n_err;
    logic                               n_hit;

    always_comb begin
        w_acc = ERR_ACC_W'(i_resid) <<< FRAC_BITS;
        for (int j = 0; j < vgl_pkg::LANES; j++) begin
            w_acc = w_acc - ERR_ACC_W'(r_cprod[j]);
        end
        // Round half up, then floor by the arithmetic shift.
        w_rnd   = w_acc + ERR_HALF;
        w_shift = w_rnd >>> FRAC_BITS;
        n_hit   = 1'b0;
        if (!LANE_ON) begin
            n_err = '0;
        end else if (i_first) begin
            n_err = i_resid;
        end else if (w_shift > ERR_MAX) begin
            n_err = ERR_MAX[vgl_pkg::ELEM_W-1:0];
            n_hit = 1'b1;
        end else if (w_shift < ERR_MIN) begin
            n_err = ERR_MIN[vgl_pkg::ELEM_W-1:0];
            n_hit = 1'b1;
        end else begin
            n_err = w_shift[vgl_pkg::ELEM_W-1:0];
        end
    end

    always_comb begin
        w_inner = '0;
        for (int j = 0; j < vgl_pkg::LANES; j++) begin
            w_inner = w_inner + vgl_pkg::INNER_W'(r_pprod[j]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.err_mul) begin
            for (int j = 0; j < vgl_pkg::LANES; j++) begin
                r_cprod[j] <= vgl_pkg::PROD_W'(
                                  $signed(i_coef_row[vgl_pkg::ELEM_W*j +: vgl_pkg::ELEM_W]))
                              * vgl_pkg::PROD_W'(i_prev[j]);
            end
        end
        if (i_ctl.err_sum) begin
            r_err <= n_err;
            r_hit <= n_hit;
        end
        if (i_ctl.prec_mul) begin
            for (int j = 0; j < vgl_pkg::LANES; j++) begin
                r_pprod[j] <= vgl_pkg::PROD_W'(
                                  $signed(i_prec_row[vgl_pkg::ELEM_W*j +: vgl_pkg::ELEM_W]))
                              * vgl_pkg::PROD_W'(i_err_all[j]);
            end
        end
        if (i_ctl.inner_sum) begin
            r_inner <= w_inner;
        end
        if (i_ctl.form_mul) begin
            r_term <= vgl_pkg::TERM_W'(r_err) * vgl_pkg::TERM_W'(r_inner);
        end
    end

    assign o_err  = r_err;
    assign o_hit  = r_hit;
    assign o_term = r_term;

endmodule
`default_nettype wire

/* src/vgl_merge.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vgl_merge
// Adds the lane terms into the quadratic form, halves it with rounding,
// updates the saturating running sum and holds the result register.
// ----------------------------------------------------------------------------
module vgl_merge #(
    parameter int FRAC_BITS = 12
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire vgl_pkg::t_merge_ctl            i_ctl,
    input  wire signed [vgl_pkg::TERM_W-1:0]    i_terms [vgl_pkg::LANES],
    input  wire                                 i_first,
    input  wire                                 i_last,
    input  wire signed [vgl_pkg::JAC_W-1:0]     i_jacobian,
    input  wire                                 i_err_hit,
    input  wire                                 i_out_ready,
    output logic                                o_out_valid,
    output logic signed [vgl_pkg::SUM_W-1:0]    o_log_likelihood,
    output logic                                o_saturated
);

    localparam int FORM_W     = vgl_pkg::TERM_W + 3;
    localparam int HALF_SHIFT = 3 * FRAC_BITS + 1 - vgl_pkg::SUM_FRAC;
    localparam int DIFF_W     = FORM_W + 1;
    localparam logic signed [FORM_W-1:0] FORM_HALF = FORM_W'(1) << (HALF_SHIFT - 1);
    localparam logic signed [DIFF_W-1:0] SUM_MAX   =
        DIFF_W'({1'b0, {(vgl_pkg::SUM_W-1){1'b1}}});
    localparam logic signed [DIFF_W-1:0] SUM_MIN   = ~SUM_MAX;

    logic signed [FORM_W-1:0]        r_half;
    logic signed [vgl_pkg::SUM_W-1:0] r_sum;
    logic                            r_sat;
    logic                            r_out_valid;
    logic signed [vgl_pkg::SUM_W-1:0] r_out_sum;
    logic                            r_out_sat;

    logic signed [FORM_W-1:0]        w_form;
    logic signed [FORM_W-1:0]        w_rnd;
    logic signed [DIFF_W-1:0]        w_base;
    logic signed [DIFF_W-1:0]        w_diff;
    logic signed [vgl_pkg::SUM_W-1:0] n_sum;
    logic                            n_sat;

    always_comb begin
        w_form = '0;
        for (int i = 0; i < vgl_pkg::LANES; i++) begin
            w_form = w_form + FORM_W'(i_terms[i]);
        end
        w_rnd = w_form + FORM_HALF;
    end

    always_comb begin
        w_base = i_first ? DIFF_W'(i_jacobian) : DIFF_W'(r_sum);
        w_diff = w_base - DIFF_W'(r_half);
        // A first column starts a fresh saturation history.
        n_sat  = (r_sat && !i_first) || i_err_hit;
        if (w_diff > SUM_MAX) begin
            n_sum = SUM_MAX[vgl_pkg::SUM_W-1:0];
            n_sat = 1'b1;
        end else if (w_diff < SUM_MIN) begin
            n_sum = SUM_MIN[vgl_pkg::SUM_W-1:0];
            n_sat = 1'b1;
        end else begin
            n_sum = w_diff[vgl_pkg::SUM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.form_sum) begin
            r_half <= w_rnd >>> HALF_SHIFT;
        end
        if (i_ctl.commit && i_last) begin
            r_out_sum <= n_sum;
            r_out_sat <= n_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum       <= '0;
            r_sat       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_ctl.commit) begin
                r_sum <= n_sum;
                r_sat <= n_sat;
            end
            if (i_ctl.commit && i_last) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_log_likelihood = r_out_sum;
    assign o_saturated      = r_out_sat;

endmodule
`default_nettype wire

/* src/var1_gaussian_log_likelihood.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// var1_gaussian_log_likelihood
// Fixed-point VAR(1) Gaussian log-likelihood accumulator over time columns.
// ----------------------------------------------------------------------------
// Each input beat carries one time column (residual and series vectors in
// Q3.12, a log Jacobian term in Q15.24, first and last flags). Four element
// lanes each form an error element and its share of the quadratic form in
// parallel, and a merge stage adds the shares into a saturating Q23.24 sum.
// A column, once accepted, goes through seven steps in the lane
// multipliers, the form reduction and the accumulator update before the
// block is ready for the next column. On a last column the sum and a
// saturation flag go to an output register, so the next column can be taken
// while that beat waits; the accumulator step waits only if a new result
// would overwrite one still not taken. Register writes are taken at any time
// but belong between series.
// ----------------------------------------------------------------------------
module var1_gaussian_log_likelihood #(
    parameter int DIMENSION     = 4,
    parameter int FRACTION_BITS = 12
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    // Configuration write port.
    input  wire                                  i_cfg_wr_en,
    input  wire [vgl_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  wire [vgl_pkg::REG_W-1:0]             i_cfg_wdata,
    // Column input.
    input  wire                                  s_axis_tvalid,
    output logic                                 s_axis_tready,
    // resid_0..resid_3, series_0..series_3, jacobian_term
    input  wire [vgl_pkg::IN_TDATA_W-1:0]        s_axis_tdata,
    // first_column
    input  wire                                  s_axis_tuser,
    input  wire                                  s_axis_tlast,
    // Result output.
    output logic                                 m_axis_tvalid,
    input  wire                                  m_axis_tready,
    // log_likelihood
    output logic [vgl_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    // saturated
    output logic                                 m_axis_tuser
);

    localparam int WORK_DIM = (DIMENSION > vgl_pkg::LANES) ? vgl_pkg::LANES :
                              ((DIMENSION < 1) ? 1 : DIMENSION);

    typedef enum logic [7:0] {
        ST_IDLE      = 8'b0000_0001,
        ST_ERR_MUL   = 8'b0000_0010,
        ST_ERR_SUM   = 8'b0000_0100,
        ST_PREC_MUL  = 8'b0000_1000,
        ST_INNER_SUM = 8'b0001_0000,
        ST_FORM_MUL  = 8'b0010_0000,
        ST_FORM_SUM  = 8'b0100_0000,
        ST_COMMIT    = 8'b1000_0000
    } t_state;

    t_state                               r_state;
    t_state                               n_state;

    logic [vgl_pkg::REG_W-1:0]            r_coef [vgl_pkg::LANES];
    logic [vgl_pkg::REG_W-1:0]            r_prec [vgl_pkg::LANES];
    vgl_pkg::t_elem                       r_prev [vgl_pkg::LANES];
    vgl_pkg::t_elem                       r_resid [vgl_pkg::LANES];
    vgl_pkg::t_elem                       r_series [vgl_pkg::LANES];
    logic signed [vgl_pkg::JAC_W-1:0]     r_jac;
    logic                                 r_first;
    logic                                 r_last;

    vgl_pkg::t_elem                       w_prev_mask [vgl_pkg::LANES];
    vgl_pkg::t_elem                       w_err [vgl_pkg::LANES];
    logic [vgl_pkg::LANES-1:0]            w_hit;
    logic signed [vgl_pkg::TERM_W-1:0]    w_term [vgl_pkg::LANES];
    vgl_pkg::t_lane_ctl                   w_lane_ctl;
    vgl_pkg::t_merge_ctl                  w_merge_ctl;
    logic                                 w_accept;
    logic                                 w_commit_ok;
    logic                                 w_out_valid;
    logic signed [vgl_pkg::SUM_W-1:0]     w_out_sum;
    logic                                 w_out_sat;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_commit_ok   = !r_last || !w_out_valid || m_axis_tready;

    always_comb begin
        case (r_state)
            ST_IDLE:      n_state = w_accept ? ST_ERR_MUL : ST_IDLE;
            ST_ERR_MUL:   n_state = ST_ERR_SUM;
            ST_ERR_SUM:   n_state = ST_PREC_MUL;
            ST_PREC_MUL:  n_state = ST_INNER_SUM;
            ST_INNER_SUM: n_state = ST_FORM_MUL;
            ST_FORM_MUL:  n_state = ST_FORM_SUM;
            ST_FORM_SUM:  n_state = ST_COMMIT;
            ST_COMMIT:    n_state = w_commit_ok ? ST_IDLE : ST_COMMIT;
            default:      n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        w_lane_ctl.err_mul   = (r_state == ST_ERR_MUL);
        w_lane_ctl.err_sum   = (r_state == ST_ERR_SUM);
        w_lane_ctl.prec_mul  = (r_state == ST_PREC_MUL);
        w_lane_ctl.inner_sum = (r_state == ST_INNER_SUM);
        w_lane_ctl.form_mul  = (r_state == ST_FORM_MUL);
        w_merge_ctl.form_sum = (r_state == ST_FORM_SUM);
        w_merge_ctl.commit   = (r_state == ST_COMMIT) && w_commit_ok;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            for (int r = 0; r < vgl_pkg::LANES; r++) begin
                r_coef[r] <= '0;
                r_prec[r] <= '0;
                r_prev[r] <= '0;
            end
        end else begin
            r_state <= n_state;
            for (int r = 0; r < vgl_pkg::LANES; r++) begin
                if (i_cfg_wr_en &&
                    i_cfg_index == vgl_pkg::CFG_COEF_BASE + vgl_pkg::CFG_IDX_W'(r)) begin
                    r_coef[r] <= i_cfg_wdata;
                end
                if (i_cfg_wr_en &&
                    i_cfg_index == vgl_pkg::CFG_PREC_BASE + vgl_pkg::CFG_IDX_W'(r)) begin
                    r_prec[r] <= i_cfg_wdata;
                end
            end
            if (w_merge_ctl.commit) begin
                for (int r = 0; r < vgl_pkg::LANES; r++) begin
                    r_prev[r] <= r_series[r];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            for (int r = 0; r < vgl_pkg::LANES; r++) begin
                r_resid[r]  <= $signed(s_axis_tdata[vgl_pkg::ELEM_W*r +: vgl_pkg::ELEM_W]);
                r_series[r] <= $signed(s_axis_tdata[vgl_pkg::SERIES_LSB + vgl_pkg::ELEM_W*r
                                                    +: vgl_pkg::ELEM_W]);
            end
            r_jac   <= $signed(s_axis_tdata[vgl_pkg::JAC_LSB +: vgl_pkg::JAC_W]);
            r_first <= s_axis_tuser;
            r_last  <= s_axis_tlast;
        end
    end

    // Elements beyond the working dimension never reach the products.
    always_comb begin
        for (int j = 0; j < vgl_pkg::LANES; j++) begin
            w_prev_mask[j] = (j < WORK_DIM) ? r_prev[j] : '0;
        end
    end

    for (genvar g = 0; g < vgl_pkg::LANES; g++) begin : g_lane
        vgl_lane #(
            .FRAC_BITS (FRACTION_BITS),
            .LANE_ON   (g < WORK_DIM)
        ) u_lane (
            .i_clk      (i_clk),
            .i_ctl      (w_lane_ctl),
            .i_coef_row (r_coef[g]),
            .i_prec_row (r_prec[g]),
            .i_prev     (w_prev_mask),
            .i_resid    (r_resid[g]),
            .i_first    (r_first),
            .i_err_all  (w_err),
            .o_err      (w_err[g]),
            .o_hit      (w_hit[g]),
            .o_term     (w_term[g])
        );
    end

    vgl_merge #(
        .FRAC_BITS (FRACTION_BITS)
    ) u_merge (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_ctl            (w_merge_ctl),
        .i_terms          (w_term),
        .i_first          (r_first),
        .i_last           (r_last),
        .i_jacobian       (r_jac),
        .i_err_hit        (|w_hit),
        .i_out_ready      (m_axis_tready),
        .o_out_valid      (w_out_valid),
        .o_log_likelihood (w_out_sum),
        .o_saturated      (w_out_sat)
    );

    assign m_axis_tvalid = w_out_valid;
    assign m_axis_tdata  = w_out_sum;
    assign m_axis_tuser  = w_out_sat;

endmodule
`default_nettype wire

/* test/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the VAR(1) Gaussian log-likelihood accumulator.
// ----------------------------------------------------------------------------
// Columns are streamed in with random valid gaps and results are drained with
// random ready stalls. A scoreboard keeps its own copy of the coefficient and
// precision rows, the previous series column and the running sum, predicts
// each emitted log-likelihood and flag, and compares them in order. The run
// covers a directed set of corner columns, random series under several
// register settings, a long output stall, and a long stretch streamed with
// no idle cycles on either side.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int LANES       = vgl_pkg::LANES;
    localparam int ELEM_W      = vgl_pkg::ELEM_W;
    localparam int REG_W       = vgl_pkg::REG_W;
    localparam int SUM_W       = vgl_pkg::SUM_W;
    localparam int JAC_W       = vgl_pkg::JAC_W;
    localparam int CFG_IDX_W   = vgl_pkg::CFG_IDX_W;
    localparam int IN_TDATA_W  = vgl_pkg::IN_TDATA_W;
    localparam int OUT_TDATA_W = vgl_pkg::OUT_TDATA_W;

    localparam int DIMENSION      = 4;
    localparam int FRACTION_BITS  = 12;
    localparam int WORK_DIM       = (DIMENSION > LANES) ? LANES : DIMENSION;
    localparam int HALF_SHIFT     = 3 * FRACTION_BITS + 1 - vgl_pkg::SUM_FRAC;
    localparam int IDLE_PCT       = 21;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 24;
    localparam int WATCHDOG_LIMIT = 4000;

    localparam logic [JAC_W-1:0] JAC_MAX = 40'h7F_FFFF_FFFF;
    localparam logic [JAC_W-1:0] JAC_MIN = 40'h80_0000_0000;

    typedef struct packed {
        logic [JAC_W-1:0]              jacobian;
        logic [LANES-1:0][ELEM_W-1:0]  series;
        logic [LANES-1:0][ELEM_W-1:0]  resid;
        logic                          first;
        logic                          last;
    } t_column;

    typedef struct packed {
        logic [SUM_W-1:0] loglik;
        logic             sat;
    } t_loglik;

    typedef logic [LANES-1:0][REG_W-1:0] t_reg_bank;

    class t_loglik_scoreboard;
        logic [REG_W-1:0] coef_rows [LANES];
        logic [REG_W-1:0] prec_rows [LANES];
        longint           prev_series [LANES];
        longint           running_sum;
        bit               sat_seen;
        t_loglik          pending_sums [$];
        int               mismatches;
        int               columns_seen;
        int               series_starts;
        int               results_checked;
        int               saturated_results;

        function new();
            int i;
            for (i = 0; i < LANES; i++) begin
                coef_rows[i]   = '0;
                prec_rows[i]   = '0;
                prev_series[i] = 0;
            end
            running_sum       = 0;
            sat_seen          = 0;
            mismatches        = 0;
            columns_seen      = 0;
            series_starts     = 0;
            results_checked   = 0;
            saturated_results = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] index, logic [REG_W-1:0] value);
            if (index >= vgl_pkg::CFG_PREC_BASE) begin
                prec_rows[index - vgl_pkg::CFG_PREC_BASE] = value;
            end else begin
                coef_rows[index - vgl_pkg::CFG_COEF_BASE] = value;
            end
        endfunction

        function longint entry_of(logic [REG_W-1:0] row, int j);
            logic signed [ELEM_W-1:0] e;
            e = row[ELEM_W*j +: ELEM_W];
            return longint'(e);
        endfunction

        // Floor of v / 2^s + 1/2; the shift is arithmetic, so this is floor.
        function longint round_half_up(longint v, int s);
            return (v + (longint'(1) << (s - 1))) >>> s;
        endfunction

        function longint saturate(longint v, int w, inout bit hit);
            longint hi;
            longint lo;
            hi = (longint'(1) << (w - 1)) - 1;
            lo = -hi - 1;
            if (v > hi) begin
                hit = 1;
                return hi;
            end
            if (v < lo) begin
                hit = 1;
                return lo;
            end
            return v;
        endfunction

        function void absorb_column(t_column c);
            longint  err [LANES];
            longint  acc;
            longint  inner;
            longint  form;
            longint  base;
            bit      hit;
            t_loglik want;
            int      i;
            int      j;
            hit  = 0;
            form = 0;
            for (i = 0; i < WORK_DIM; i++) begin
                if (c.first) begin
                    err[i] = longint'($signed(c.resid[i]));
                end else begin
                    acc = longint'($signed(c.resid[i])) * (longint'(1) << FRACTION_BITS);
                    for (j = 0; j < WORK_DIM; j++)
                        acc -= entry_of(coef_rows[i], j) * prev_series[j];
                    err[i] = saturate(round_half_up(acc, FRACTION_BITS), ELEM_W, hit);
                end
            end
            for (i = 0; i < WORK_DIM; i++) begin
                inner = 0;
                for (j = 0; j < WORK_DIM; j++)
                    inner += entry_of(prec_rows[i], j) * err[j];
                form += err[i] * inner;
            end
            if (c.first) begin
                sat_seen = 0;
                base = longint'($signed(c.jacobian));
                series_starts++;
            end else begin
                base = running_sum;
            end
            running_sum = saturate(base - round_half_up(form, HALF_SHIFT), SUM_W, hit);
            if (hit)
                sat_seen = 1;
            for (i = 0; i < LANES; i++)
                prev_series[i] = longint'($signed(c.series[i]));
            columns_seen++;
            if (c.last) begin
                want.loglik = running_sum[SUM_W-1:0];
                want.sat    = sat_seen;
                pending_sums.push_back(want);
            end
        endfunction

        function int pending();
            return pending_sums.size();
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            $display("MISMATCH %0d: %s", mismatches, msg);
        endtask

        task check_result(logic [SUM_W-1:0] loglik, logic sat);
            t_loglik want;
            if (pending_sums.size() == 0) begin
                report_mismatch($sformatf("unexpected result %h sat %b", loglik, sat));
                return;
            end
            want = pending_sums.pop_front();
            results_checked++;
            if (sat)
                saturated_results++;
            if (loglik !== want.loglik || sat !== want.sat)
                report_mismatch($sformatf("result %0d: got %h sat %b, expected %h sat %b",
                                          results_checked, loglik, sat, want.loglik,
                                          want.sat));
        endtask

        task check_drained();
            if (pending_sums.size() != 0)
                report_mismatch($sformatf("%0d results never arrived", pending_sums.size()));
        endtask
    endclass

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_cfg_wr_en;
    logic [CFG_IDX_W-1:0]    i_cfg_index;
    logic [REG_W-1:0]        i_cfg_wdata;
    logic                    s_axis_tvalid;
    logic                    s_axis_tready;
    logic [IN_TDATA_W-1:0]   s_axis_tdata;
    logic                    s_axis_tuser;
    logic                    s_axis_tlast;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready;
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;
    logic                    m_axis_tuser;

    t_loglik_scoreboard sb;
    int idle_pct        = IDLE_PCT;
    int hold_request    = 0;
    int quiet_cycles    = 0;
    int settings_loaded = 0;

    var1_gaussian_log_likelihood #(
        .DIMENSION     (DIMENSION),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Result sink. A pending hold request overrides the random stalls.
    initial begin : result_sink
        int hold_left;
        hold_left     = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tuser);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || i_cfg_wr_en) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("Watchdog: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [ELEM_W-1:0] random_elem();
        int k;
        k = $urandom_range(99);
        if (k < 12) begin
            case ($urandom_range(3))
                0:       return 16'h8000;
                1:       return 16'h7FFF;
                2:       return 16'h0000;
                default: return 16'hFFFF;
            endcase
        end
        if (k < 50)
            return 16'($urandom_range(8191) - 4096);
        return 16'($urandom);
    endfunction

    function automatic logic [JAC_W-1:0] random_jacobian();
        logic [63:0] v;
        logic [31:0] w;
        int          k;
        k = $urandom_range(99);
        w = $urandom;
        if (k < 5)
            return JAC_MIN;
        if (k < 10)
            return JAC_MAX;
        if (k < 50)
            v = {{32{w[31]}}, w};
        else
            v = {$urandom, w};
        return v[JAC_W-1:0];
    endfunction

    function automatic t_column random_column(bit first, bit last);
        t_column c;
        int      i;
        for (i = 0; i < LANES; i++) begin
            c.resid[i]  = random_elem();
            c.series[i] = random_elem();
        end
        c.jacobian = random_jacobian();
        c.first    = first;
        c.last     = last;
        return c;
    endfunction

    function automatic t_column column(logic [ELEM_W-1:0] r, logic [ELEM_W-1:0] w, bit first,
                                       bit last, logic [JAC_W-1:0] jac);
        t_column c;
        c.resid    = {LANES{r}};
        c.series   = {LANES{w}};
        c.jacobian = jac;
        c.first    = first;
        c.last     = last;
        return c;
    endfunction

    function automatic t_reg_bank diagonal_bank(logic [ELEM_W-1:0] diag, logic [ELEM_W-1:0] off);
        t_reg_bank bank;
        int        r;
        int        j;
        for (r = 0; r < LANES; r++)
            for (j = 0; j < LANES; j++)
                bank[r][ELEM_W*j +: ELEM_W] = (r == j) ? diag : off;
        return bank;
    endfunction

    // Entries uniform in [-span, span - 1].
    function automatic t_reg_bank random_bank(int span);
        t_reg_bank bank;
        int        r;
        int        j;
        for (r = 0; r < LANES; r++)
            for (j = 0; j < LANES; j++)
                bank[r][ELEM_W*j +: ELEM_W] = 16'($urandom_range(2 * span - 1) - span);
        return bank;
    endfunction

    task automatic load_registers(t_reg_bank coef, t_reg_bank prec);
        logic [CFG_IDX_W-1:0] idx;
        int                   r;
        for (r = 0; r < 2 * LANES; r++) begin
            if (r < LANES)
                idx = vgl_pkg::CFG_COEF_BASE + r[CFG_IDX_W-1:0];
            else
                idx = vgl_pkg::CFG_PREC_BASE + r[CFG_IDX_W-1:0] - vgl_pkg::CFG_PREC_BASE;
            i_cfg_wr_en <= 1'b1;
            i_cfg_index <= idx;
            i_cfg_wdata <= (r < LANES) ? coef[r] : prec[r - LANES];
            sb.set_register(idx, (r < LANES) ? coef[r] : prec[r - LANES]);
            @(posedge i_clk);
            @(negedge i_clk);
        end
        i_cfg_wr_en <= 1'b0;
        settings_loaded++;
    endtask

    task automatic send_column(t_column c);
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {c.jacobian, c.series, c.resid};
        s_axis_tuser  <= c.first;
        s_axis_tlast  <= c.last;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.absorb_column(c);
        @(negedge i_clk);
    endtask

    // Stop offering columns until every predicted result is in, then give
    // any trailing non-emitting column time to leave the pipeline.
    task automatic settle_results();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Mostly complete series; the rest continue an old sum or start a series
    // that never emits.
    task automatic run_random_series(int count);
        int sent;
        int kind;
        int len;
        int k;
        sent = 0;
        while (sent < count) begin
            kind = $urandom_range(99);
            len  = (kind < 80) ? $urandom_range(10, 1) : $urandom_range(4, 1);
            if (len > count - sent)
                len = count - sent;
            for (k = 0; k < len; k++) begin
                send_column(random_column((kind < 80 || kind >= 90) && k == 0,
                                          kind < 90 && k == len - 1));
                sent++;
            end
        end
    endtask

    initial begin : stimulus
        t_column c;
        sb            = new();
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_wdata   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        s_axis_tlast  = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        load_registers(diagonal_bank(16'h0800, 16'h0100), diagonal_bank(16'h1000, 16'h0000));

        // Columns before any series start, then a continuation past a result.
        send_column(column(16'h0100, 16'h7FFF, 1'b0, 1'b0, 40'h0));
        send_column(column(16'hFF00, 16'h8000, 1'b0, 1'b1, 40'h0));
        send_column(column(16'h0000, 16'h0000, 1'b0, 1'b1, 40'h12_3456_789A));
        send_column(column(16'h0000, 16'h0000, 1'b1, 1'b1, JAC_MAX));
        send_column(column(16'h0000, 16'h0000, 1'b1, 1'b1, JAC_MIN));
        // Full-scale previous column drives the error elements into saturation.
        send_column(column(16'h8000, 16'h8000, 1'b1, 1'b0, 40'h0));
        send_column(column(16'h7FFF, 16'h7FFF, 1'b0, 1'b0, JAC_MAX));
        send_column(column(16'h0000, 16'h0000, 1'b0, 1'b1, 40'h0));
        // A new series clears the flag.
        send_column(column(16'h0001, 16'h0001, 1'b1, 1'b0, 40'hFF_FFFF_FFFF));
        send_column(column(16'hFFFF, 16'hFFFF, 1'b0, 1'b1, 40'h0));
        send_column(column(16'h8000, 16'h8000, 1'b1, 1'b1, 40'h0));
        // A single unit error lands exactly on the rounding tie of the half form.
        c = column(16'h0000, 16'h0000, 1'b1, 1'b1, 40'h0);
        c.resid[LANES-1] = 16'h0001;
        send_column(c);
        c.resid  = {16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000};
        c.series = {16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF};
        c.first  = 1'b1;
        c.last   = 1'b0;
        send_column(c);
        c.resid  = {16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF};
        c.first  = 1'b0;
        c.last   = 1'b1;
        send_column(c);

        // Long output stall while one-column series keep arriving.
        hold_request = HOLD_CYCLES;
        repeat (16) send_column(random_column(1'b1, 1'b1));
        settle_results();

        load_registers(random_bank(2048), random_bank(4096));
        run_random_series(400);
        settle_results();

        load_registers(random_bank(32768), random_bank(32768));
        run_random_series(300);
        settle_results();

        load_registers(diagonal_bank(16'h8000, 16'h8000), diagonal_bank(16'h7FFF, 16'h7FFF));
        run_random_series(80);
        settle_results();

        load_registers(diagonal_bank(16'h7FFF, 16'h7FFF), diagonal_bank(16'h8000, 16'h8000));
        run_random_series(80);
        settle_results();

        // A long stretch with no idle cycles on either side.
        idle_pct = 0;
        load_registers(random_bank(4096), random_bank(16384));
        run_random_series(300);
        settle_results();
        idle_pct = IDLE_PCT;

        load_registers(random_bank(1024), random_bank(8192));
        run_random_series(300);
        settle_results();

        sb.check_drained();
        $display("Streamed %0d columns (%0d series starts) under %0d register settings.",
                 sb.columns_seen, sb.series_starts, settings_loaded);
        $display("Checked %0d log-likelihood results, %0d with the saturation flag set.",
                 sb.results_checked, sb.saturated_results);
        if (sb.mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
